@@ design/cafd_pkg.sv @@
// Shared types and constants for the codebook ADPCM frame decoder.
`default_nettype none
package cafd_pkg;
  localparam int NUM_PREDICTORS = 16;
  localparam int NUM_POS = 16;
  localparam int NUM_LANES = 8;
  localparam int PRED_W = (NUM_PREDICTORS > 1) ? $clog2(NUM_PREDICTORS) : 1;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 16;
  localparam int FRAC_SHIFT = 11;
  localparam int MAX_SHIFT = 12;
  localparam int TERM_LAST = 9;
  localparam int MAC_LAST = 10;

  typedef enum logic [1:0] {
    CMD_DECODE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_HIST   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic prod_en;
    logic acc_en;
    logic acc_first;
  } lane_ctl_t;
endpackage
`default_nettype wire

@@ design/cafd_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module cafd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ design/cafd_lane.sv @@
// One multiply-accumulate lane: registered product, 32-bit wrapping accumulator.
`default_nettype none
module cafd_lane (
  input  wire logic               clk,
  input  wire cafd_pkg::lane_ctl_t ctl,
  input  wire logic signed [15:0] coef,
  input  wire logic signed [15:0] smp,
  output logic signed [31:0]      acc
);
  logic signed [31:0] prod_r, prod_nxt;
  logic signed [31:0] acc_r, acc_nxt;

  always_comb begin
    prod_nxt = ctl.prod_en ? coef * smp : prod_r;
    if (!ctl.acc_en) begin
      acc_nxt = acc_r;
    end else if (ctl.acc_first) begin
      acc_nxt = prod_r;
    end else begin
      acc_nxt = acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;
endmodule
`default_nettype wire

@@ design/cafd_merge.sv @@
// Scales and saturates the lane sums, holds them and streams them out in order.
`default_nettype none
module cafd_merge (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               second_half,
  input  wire logic signed [31:0] acc [cafd_pkg::NUM_LANES],
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [15:0]             out_tdata,   // [15:0] pcm_sample
  output logic                    out_tlast,   // last_sample
  output logic                    done,
  output logic signed [15:0]      y_older,
  output logic signed [15:0]      y_newer
);
  logic signed [15:0] y      [cafd_pkg::NUM_LANES];
  logic signed [15:0] buf_r  [cafd_pkg::NUM_LANES];
  logic [2:0]         idx_r, idx_nxt;
  logic               busy_r, busy_nxt;
  logic               last_r, last_nxt;
  logic               fire;

  always_comb begin
    logic signed [20:0] q;
    for (int i = 0; i < cafd_pkg::NUM_LANES; i++) begin
      q = 21'(acc[i] >>> cafd_pkg::FRAC_SHIFT);
      if (q > 21'sd32767) begin
        y[i] = 16'sh7fff;
      end else if (q < -21'sd32768) begin
        y[i] = 16'sh8000;
      end else begin
        y[i] = q[15:0];
      end
    end
  end

  assign fire = busy_r && out_tready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    last_nxt = last_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
      last_nxt = second_half;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r == 3'(cafd_pkg::NUM_LANES - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
      last_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < cafd_pkg::NUM_LANES; i++) begin
        buf_r[i] <= y[i];
      end
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = buf_r[idx_r];
  assign out_tlast  = last_r && (idx_r == 3'(cafd_pkg::NUM_LANES - 1));
  assign done       = fire && (idx_r == 3'(cafd_pkg::NUM_LANES - 1));
  assign y_older    = y[cafd_pkg::NUM_LANES - 2];
  assign y_newer    = y[cafd_pkg::NUM_LANES - 1];
endmodule
`default_nettype wire

@@ design/codebook_adpcm_frame_decoder.sv @@
// Top level of the codebook ADPCM frame decoder.
//
//  port group | dir | tdata / tuser contents
//  in_        | in  | tdata: header, nibbles, coef_index, coef_value, older, newer; tuser: command
//  out_       | out | tdata: pcm_sample; tlast: last_sample
//
//  A decode steps through an accept, a codebook read and, for each of two halves, the MAC terms,
//  a load and eight output words; eight lanes run the ten product terms of each half in turn.
//  Input is taken only while idle.
//  Reset clears history and codebook valid bits; output stalls hold the current word.
`default_nettype none
module codebook_adpcm_frame_decoder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] frame_header, [71:8] frame_nibbles, [79:72] coef_index,
  // [95:80] coef_value, [111:96] hist_older, [127:112] hist_newer
  input  wire logic [127:0] in_tdata,
  input  wire logic [1:0]   in_tuser,    // [1:0] command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata,   // [15:0] pcm_sample
  output logic              out_tlast    // last_sample
);
  localparam int NP = cafd_pkg::NUM_PREDICTORS;
  localparam int NL = cafd_pkg::NUM_LANES;
  localparam int PW = cafd_pkg::PRED_W;

  cafd_pkg::state_t state_r, state_nxt;
  cafd_pkg::cmd_t   cmd;

  logic [7:0]  in_header, in_cidx;
  logic [63:0] in_nibbles;
  logic signed [15:0] in_cval, in_older, in_newer;

  logic [3:0]  pred_r, pred_nxt;
  logic [3:0]  shift_r, shift_nxt;
  logic [63:0] nib_r, nib_nxt;
  logic        half_r, half_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic signed [15:0] hold_r, hold_nxt, hnew_r, hnew_nxt;
  logic [NP-1:0][cafd_pkg::NUM_POS-1:0] vld_r, vld_nxt;
  logic [cafd_pkg::NUM_POS-1:0] rowv_r, rowv_nxt;

  logic accept, coef_wr, coef_ok, load, done;
  logic [PW-1:0] ram_addr;
  logic [15:0] ram_q [cafd_pkg::NUM_POS];
  logic signed [15:0] cf [cafd_pkg::NUM_POS];
  logic signed [15:0] xv [NL];
  logic signed [15:0] l_coef [NL];
  logic signed [15:0] l_smp [NL];
  logic signed [31:0] l_acc [NL];
  cafd_pkg::lane_ctl_t lctl;
  logic signed [15:0] y_older, y_newer;

  assign in_header  = in_tdata[7:0];
  assign in_nibbles = in_tdata[71:8];
  assign in_cidx    = in_tdata[79:72];
  assign in_cval    = in_tdata[95:80];
  assign in_older   = in_tdata[111:96];
  assign in_newer   = in_tdata[127:112];
  assign cmd        = cafd_pkg::cmd_t'(in_tuser);

  assign accept  = in_tvalid && in_tready;
  assign coef_ok = {1'b0, in_cidx[7:4]} < 5'(NP);
  assign coef_wr = accept && (cmd == cafd_pkg::CMD_COEF) && coef_ok;
  assign ram_addr = (state_r == cafd_pkg::ST_IDLE) ? in_cidx[PW+3:4] : pred_r[PW-1:0];

  for (genvar j = 0; j < cafd_pkg::NUM_POS; j++) begin : g_book
    cafd_ram #(.WIDTH(16), .DEPTH(NP)) u_ram (
      .clk   (clk),
      .we    (coef_wr && (in_cidx[3:0] == 4'(j))),
      .addr  (ram_addr),
      .wdata (in_cval),
      .rdata (ram_q[j])
    );
    assign cf[j] = rowv_r[j] ? signed'(ram_q[j]) : 16'sd0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cafd_pkg::ST_IDLE: begin
        if (accept && cmd == cafd_pkg::CMD_DECODE) begin
          state_nxt = cafd_pkg::ST_READ;
        end
      end
      cafd_pkg::ST_READ: state_nxt = cafd_pkg::ST_MAC;
      cafd_pkg::ST_MAC: begin
        if (cnt_r == 4'(cafd_pkg::MAC_LAST)) begin
          state_nxt = cafd_pkg::ST_LOAD;
        end
      end
      cafd_pkg::ST_LOAD: state_nxt = cafd_pkg::ST_EMIT;
      cafd_pkg::ST_EMIT: begin
        if (done) begin
          state_nxt = half_r ? cafd_pkg::ST_IDLE : cafd_pkg::ST_MAC;
        end
      end
      default: state_nxt = cafd_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_tready = (state_r == cafd_pkg::ST_IDLE);
    load      = (state_r == cafd_pkg::ST_LOAD);
    lctl.prod_en   = (state_r == cafd_pkg::ST_MAC) && (cnt_r <= 4'(cafd_pkg::TERM_LAST));
    lctl.acc_en    = (state_r == cafd_pkg::ST_MAC) && (cnt_r != 4'd0);
    lctl.acc_first = (cnt_r == 4'd1);
    pred_nxt  = pred_r;
    shift_nxt = shift_r;
    nib_nxt   = nib_r;
    half_nxt  = half_r;
    cnt_nxt   = (state_r == cafd_pkg::ST_MAC) ? cnt_r + 4'd1 : 4'd0;
    hold_nxt  = hold_r;
    hnew_nxt  = hnew_r;
    vld_nxt   = vld_r;
    rowv_nxt  = rowv_r;
    if (accept && cmd == cafd_pkg::CMD_DECODE) begin
      pred_nxt  = in_header[3:0];
      shift_nxt = (in_header[7:4] >= 4'(cafd_pkg::MAX_SHIFT)) ? 4'(cafd_pkg::MAX_SHIFT)
                                                             : in_header[7:4];
      nib_nxt   = in_nibbles;
      half_nxt  = 1'b0;
    end
    if (accept && cmd == cafd_pkg::CMD_HIST) begin
      hold_nxt = in_older;
      hnew_nxt = in_newer;
    end
    if (coef_wr) begin
      vld_nxt[in_cidx[PW+3:4]][in_cidx[3:0]] = 1'b1;
    end
    if (state_r == cafd_pkg::ST_READ) begin
      rowv_nxt = ({1'b0, pred_r} < 5'(NP)) ? vld_r[pred_r[PW-1:0]] : '0;
    end
    if (load) begin
      hold_nxt = y_older;
      hnew_nxt = y_newer;
    end
    if (state_r == cafd_pkg::ST_EMIT && done) begin
      half_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cafd_pkg::ST_IDLE;
      half_r  <= 1'b0;
      cnt_r   <= 4'd0;
      hold_r  <= 16'sd0;
      hnew_r  <= 16'sd0;
      vld_r   <= '0;
      rowv_r  <= '0;
    end else begin
      state_r <= state_nxt;
      half_r  <= half_nxt;
      cnt_r   <= cnt_nxt;
      hold_r  <= hold_nxt;
      hnew_r  <= hnew_nxt;
      vld_r   <= vld_nxt;
      rowv_r  <= rowv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pred_r  <= pred_nxt;
    shift_r <= shift_nxt;
    nib_r   <= nib_nxt;
  end

  // scaled input samples of the current half
  always_comb begin
    logic [3:0] nb;
    for (int i = 0; i < NL; i++) begin
      nb    = half_r ? nib_r[31 - 4*i -: 4] : nib_r[63 - 4*i -: 4];
      xv[i] = 16'(signed'(nb)) <<< shift_r;
    end
  end

  // per-lane operand selection over the ten product terms
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      l_coef[i] = 16'sd0;
      l_smp[i]  = 16'sd0;
      if (cnt_r == 4'd0) begin
        l_coef[i] = cf[i];
        l_smp[i]  = hold_r;
      end else if (cnt_r == 4'd1) begin
        l_coef[i] = cf[NL + i];
        l_smp[i]  = hnew_r;
      end else if (cnt_r == 4'(cafd_pkg::TERM_LAST)) begin
        l_coef[i] = 16'sd2048;
        l_smp[i]  = xv[i];
      end else begin
        for (int k = 0; k < NL - 1; k++) begin
          if (cnt_r == 4'(k + 2) && k < i) begin
            l_coef[i] = cf[NL + i - 1 - k];
            l_smp[i]  = xv[k];
          end
        end
      end
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_lane
    cafd_lane u_lane (
      .clk  (clk),
      .ctl  (lctl),
      .coef (l_coef[i]),
      .smp  (l_smp[i]),
      .acc  (l_acc[i])
    );
  end

  cafd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .second_half (half_r),
    .acc         (l_acc),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .done        (done),
    .y_older     (y_older),
    .y_newer     (y_newer)
  );

  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == cafd_pkg::ST_EMIT)
    else $error("output word outside emit");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> state_r == cafd_pkg::ST_IDLE)
    else $error("frame did not end after last word");
  a_decode_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == cafd_pkg::CMD_DECODE |=> state_r == cafd_pkg::ST_READ)
    else $error("decode not started");
  a_half_sets: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cafd_pkg::ST_EMIT && done && !half_r |=> half_r && state_r == cafd_pkg::ST_MAC)
    else $error("second half not started");
endmodule
`default_nettype wire

@@ bench/codebook_adpcm_frame_decoder_chk.sv @@
// Checker for the codebook ADPCM frame decoder: predicts samples and compares.
`timescale 1ns / 100ps
module codebook_adpcm_frame_decoder_chk (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [127:0] in_tdata,
  input  wire logic [1:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [15:0]  out_tdata,
  input  wire logic         out_tlast,
  output int                err_cnt,
  output int                pend_cnt,
  output int                word_cnt
);
  logic signed [15:0] book [cafd_pkg::NUM_PREDICTORS*16];
  logic signed [15:0] h_old, h_new;
  logic [16:0] pcm_q[$];

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic signed [31:0] coef(input int p, input int pos);
    if (p >= cafd_pkg::NUM_PREDICTORS) return 0;
    return 32'(book[p*16+pos]);
  endfunction

  function automatic logic signed [15:0] sat_shift(input logic signed [31:0] acc);
    logic signed [31:0] q;
    q = acc >>> cafd_pkg::FRAC_SHIFT;
    if (q > 32767) return 16'sd32767;
    if (q < -32768) return -16'sd32768;
    return q[15:0];
  endfunction

  task automatic decode_frame(input logic [7:0] hdr, input logic [63:0] codes);
    int p, sh;
    logic signed [31:0] x [8];
    logic signed [31:0] acc;
    logic signed [15:0] y [8];
    logic [3:0] nib;
    p = hdr[3:0];
    sh = (hdr[7:4] >= cafd_pkg::MAX_SHIFT) ? cafd_pkg::MAX_SHIFT : hdr[7:4];
    for (int h = 0; h < 2; h++) begin
      for (int i = 0; i < 8; i++) begin
        nib = codes[60-4*(h*8+i) +: 4];
        x[i] = 32'(signed'(nib)) <<< sh;
      end
      for (int i = 0; i < 8; i++) begin
        acc = coef(p, i) * 32'(h_old) + coef(p, 8+i) * 32'(h_new);
        for (int k = 0; k < i; k++) acc += coef(p, 8+i-1-k) * x[k];
        acc += x[i] * 2048;
        y[i] = sat_shift(acc);
        pcm_q.push_back({(h == 1 && i == 7), y[i]});
      end
      h_old = y[6];
      h_new = y[7];
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (book[i]) book[i] <= '0;
      h_old <= '0;
      h_new <= '0;
      err_cnt <= 0;
      word_cnt <= 0;
      pcm_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        word_cnt <= word_cnt + 1;
        if (pcm_q.size() == 0) report($sformatf("unexpected word %h", out_tdata));
        else begin
          logic [16:0] e;
          e = pcm_q.pop_front();
          if (out_tdata !== e[15:0])
            report($sformatf("pcm got %h exp %h", out_tdata, e[15:0]));
          if (out_tlast !== e[16])
            report($sformatf("tlast got %b exp %b", out_tlast, e[16]));
        end
      end
      if (in_tvalid && in_tready) begin
        case (cafd_pkg::cmd_t'(in_tuser))
          cafd_pkg::CMD_COEF: if (in_tdata[79:72] < cafd_pkg::NUM_PREDICTORS*16)
            book[in_tdata[79:72]] = in_tdata[95:80];
          cafd_pkg::CMD_HIST: begin
            h_old = in_tdata[111:96];
            h_new = in_tdata[127:112];
          end
          cafd_pkg::CMD_DECODE: decode_frame(in_tdata[7:0], in_tdata[71:8]);
          default: ;
        endcase
      end
    end
  end

  assign pend_cnt = pcm_q.size();
endmodule

@@ bench/codebook_adpcm_frame_decoder_tb.sv @@
// Testbench top: drives commands and frames into the decoder and gives the verdict.
`timescale 1ns / 100ps
module codebook_adpcm_frame_decoder_tb;
  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0, out_tlast;
  logic [127:0] in_tdata = '0;
  logic [1:0] in_tuser = cafd_pkg::CMD_NONE;
  logic [15:0] out_tdata;
  int err_cnt, pend_cnt, word_cnt, idle_cyc, n_items;

  always #4 clk = ~clk;

  codebook_adpcm_frame_decoder u_top (.*);
  codebook_adpcm_frame_decoder_chk u_chk (.*);

  task automatic send(input cafd_pkg::cmd_t c, input logic [127:0] d);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= c;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    n_items++;
  endtask

  function automatic logic [127:0] frame(input logic [7:0] h, input logic [63:0] n);
    return {32'($urandom), 24'($urandom), n, h};
  endfunction

  function automatic logic [127:0] coef_w(input logic [7:0] i, input logic [15:0] v);
    return {32'h0, v, i, 72'h0};
  endfunction

  function automatic logic [127:0] hist_w(input logic [15:0] o, input logic [15:0] n);
    return {n, o, 96'h0};
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // downstream stall, drawn per word
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_tready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > 2000) begin
      $display("[codebook_adpcm_frame_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: reset codebook, extremes, special cases
    send(cafd_pkg::CMD_DECODE, frame(8'h00, 64'h7777_7777_8888_8888));
    for (int i = 0; i < 16; i++)
      send(cafd_pkg::CMD_COEF, coef_w(8'(i), (i[0]) ? 16'h7fff : 16'h8000));
    send(cafd_pkg::CMD_COEF, coef_w(8'hff, 16'h1234));
    send(cafd_pkg::CMD_HIST, hist_w(16'h8000, 16'h7fff));
    send(cafd_pkg::CMD_DECODE, frame(8'hf0, 64'h8f7f_0180_ffff_0000));
    send(cafd_pkg::CMD_DECODE, frame(8'hc0, 64'h7777_7777_7777_7777));
    send(cafd_pkg::CMD_NONE, '1);
    send(cafd_pkg::CMD_DECODE, frame(8'hbf, 64'hffff_ffff_ffff_ffff));
    send(cafd_pkg::CMD_DECODE, frame(8'h00, 64'h0));
    // random: mostly decodes with random headers, plus codebook loads, history writes and no-op commands
    while (n_items < 410) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send(cafd_pkg::CMD_COEF, coef_w(8'($urandom_range(0, 255)),
                  ($urandom_range(0, 3) == 0) ? {$urandom_range(0,1) ? 16'h7fff : 16'h8000}
                  : 16'($urandom)));
        3: send(cafd_pkg::CMD_HIST, hist_w(16'($urandom), 16'($urandom)));
        4: send(cafd_pkg::CMD_NONE, {rnd64(), rnd64()});
        default: send(cafd_pkg::CMD_DECODE, frame(8'($urandom), rnd64()));
      endcase
    end
    in_tvalid <= 0;
    while (pend_cnt != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("ran %0d input words, checked %0d pcm words", n_items, word_cnt);
    $display("covered all commands, saturation, scale clamp and the top codebook index");
    if (err_cnt == 0) $display("[codebook_adpcm_frame_decoder] OK");
    else $display("[codebook_adpcm_frame_decoder] ERROR");
    $finish;
  end
endmodule
